FILE: hw/rtl/ldw_pkg.sv
// ----------------------------------------------------------------------------
// ldw_pkg
// Shared types and constants of the least loaded window dispatcher.
// ----------------------------------------------------------------------------
package ldw_pkg;

    localparam int WIN_CAP = 16;

    localparam logic [31:0] LOAD_MAX   = 32'hFFFF_FFFF;
    localparam logic [15:0] TICKET_MAX = 16'hFFFF;

    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_DIST = 1'b1;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_TOTAL  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] duration;
    } t_req;

    typedef struct packed {
        logic        kind;
        logic [15:0] ticket;
        logic [3:0]  window;
        logic [31:0] load;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } t_mem_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_UPDATE
    } t_state;

endpackage

FILE: hw/rtl/ldw_mem.sv
// ----------------------------------------------------------------------------
// ldw_mem
// Window load memory: one write and one registered read port, with a valid
// bit per entry so that reset and distribute clear all loads at once.
// ----------------------------------------------------------------------------
module ldw_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ldw_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [31:0]       i_wr_data,
    output logic [31:0]       o_rd_data
);
    import ldw_pkg::*;

    logic [31:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [31:0]      r_q;
    logic             r_qv;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_ctl.rd_en) begin
                r_qv <= r_vld[i_rd_addr];
            end
            if (i_ctl.clr_all) begin
                r_vld <= '0;
            end else if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_qv ? r_q : 32'd0;

`ifndef NO_ASSERTIONS
    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_en |-> !i_ctl.rd_en)
        else $error("read and write in the same cycle");
    a_clr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr_all |=> r_vld == '0)
        else $error("valid bits not cleared");
    a_wr_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_en && !i_ctl.clr_all |=> r_vld[$past(i_wr_addr)])
        else $error("written entry not valid");
`endif

endmodule

FILE: hw/rtl/ldw_ctrl.sv
// ----------------------------------------------------------------------------
// ldw_ctrl
// Sequencer: scans the active windows through the load memory, keeps the
// least loaded one, writes back the saturated sum or emits the totals.
// ----------------------------------------------------------------------------
module ldw_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ldw_pkg::t_req     i_req,
    input  logic              i_cfg_we,
    input  logic [4:0]        i_cfg_wdata,
    output ldw_pkg::t_mem_ctl o_mem_ctl,
    output logic [AW-1:0]     o_rd_addr,
    output logic [AW-1:0]     o_wr_addr,
    output logic [31:0]       o_wr_data,
    input  logic [31:0]       i_rd_data,
    output logic              o_valid,
    output ldw_pkg::t_rsp     o_rsp
);
    import ldw_pkg::*;

    t_state        r_state, n_state;
    logic [4:0]    r_wc;
    logic [15:0]   r_ticket;
    logic          r_op;
    logic [15:0]   r_dur;
    logic [AW-1:0] r_nm1;
    logic [AW-1:0] r_idx;
    logic          r_pend;
    logic [AW-1:0] r_pidx;
    logic [AW-1:0] r_best;
    logic [31:0]   r_best_load;
    logic          r_out_vld, n_out_vld;
    t_rsp          r_out, n_out;
    logic [AW-1:0] nm1;
    logic [32:0]   sum_ext;
    logic [31:0]   sum;
    logic          accept;
    logic          pend_last;

    assign accept    = start && (r_state == ST_IDLE);
    assign pend_last = (r_pidx == r_nm1);
    assign sum_ext   = {1'b0, r_best_load} + {17'd0, r_dur};
    assign sum       = sum_ext[32] ? LOAD_MAX : sum_ext[31:0];

    always_comb begin
        if (r_wc == 5'd0) begin
            nm1 = '0;
        end else if (r_wc > 5'(DEPTH)) begin
            nm1 = AW'(DEPTH - 1);
        end else begin
            nm1 = AW'(r_wc - 5'd1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_nm1) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = (r_op == OP_ENQ) ? ST_UPDATE : ST_IDLE;
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        o_mem_ctl = '0;
        o_rd_addr = r_idx;
        o_wr_addr = r_best;
        o_wr_data = sum;
        n_out_vld = 1'b0;
        n_out     = r_out;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_SCAN: begin
                o_mem_ctl.rd_en = 1'b1;
            end
            ST_WAIT: begin
            end
            ST_UPDATE: begin
                o_mem_ctl.wr_en = 1'b1;
                n_out_vld       = 1'b1;
                n_out.kind      = KIND_ASSIGN;
                n_out.ticket    = r_ticket;
                n_out.window    = 4'(r_best);
                n_out.load      = sum;
                n_out.last      = 1'b1;
            end
            default: begin
            end
        endcase
        if (r_pend && (r_op == OP_DIST)) begin
            n_out_vld         = 1'b1;
            n_out.kind        = KIND_TOTAL;
            n_out.ticket      = 16'd0;
            n_out.window      = 4'(r_pidx);
            n_out.load        = i_rd_data;
            n_out.last        = pend_last;
            o_mem_ctl.clr_all = pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wc      <= 5'd1;
            r_ticket  <= 16'd0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= o_mem_ctl.rd_en;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_wc <= i_cfg_wdata;
            end
            if (accept && (i_req.operation == OP_ENQ) && (r_ticket != TICKET_MAX)) begin
                r_ticket <= r_ticket + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pidx <= r_idx;
        if (accept) begin
            r_op  <= i_req.operation;
            r_dur <= i_req.duration;
            r_nm1 <= nm1;
            r_idx <= '0;
        end else if (o_mem_ctl.rd_en) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_pend && ((r_pidx == '0) || (i_rd_data < r_best_load))) begin
            r_best      <= r_pidx;
            r_best_load <= i_rd_data;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");
    a_assign_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.kind == KIND_ASSIGN) |-> o_rsp.last && (o_rsp.ticket != 16'd0))
        else $error("assignment result without last or ticket");
    a_total_ticket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.kind == KIND_TOTAL) |-> (o_rsp.ticket == 16'd0))
        else $error("total report with nonzero ticket");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_mem_ctl.rd_en && !o_mem_ctl.wr_en)
        else $error("memory access while idle");
`endif

endmodule

FILE: hw/rtl/least_loaded_window_dispatcher.sv
// ----------------------------------------------------------------------------
// least_loaded_window_dispatcher
// Greedy least loaded assignment of jobs to service windows, with per-window
// total reports that clear all loads.
//
//   channel   signals                      direction
//   request   start, busy, i_req           in
//   result    o_valid, o_rsp               out
//   config    i_cfg_we, i_cfg_wdata        in
//
// an enqueue request occupies the block for the scan of the active
// windows, a wait state and the update, a distribute request for the
// scan and the wait state; the scan reads one window per cycle from the
// single read port of the load memory. results are registered and come
// one per cycle during totals. the receiver cannot stall; busy is high
// from acceptance until the sequencer is back in idle. synchronous reset
// clears all loads, the ticket counter and sets the window count to one.
// ----------------------------------------------------------------------------
module least_loaded_window_dispatcher #(
    parameter int MAX_WINDOWS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ldw_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [4:0]    i_cfg_wdata,
    output logic          o_valid,
    output ldw_pkg::t_rsp o_rsp
);
    import ldw_pkg::*;

    localparam int DEPTH = (MAX_WINDOWS < WIN_CAP) ? MAX_WINDOWS : WIN_CAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [31:0]   rd_data;

    ldw_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mem_ctl   (mem_ctl),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

    ldw_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

FILE: verif/ldw_dispatch_check.sv
// ----------------------------------------------------------------------------
// ldw_dispatch_check
// Watches the request, config and result channels of the least loaded window
// dispatcher. It keeps its own copy of the window loads, the ticket counter
// and the window count, and predicts the results of each accepted request.
// It then compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldw_dispatch_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  ldw_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [4:0]    i_cfg_wdata,
    input  logic          i_valid,
    input  ldw_pkg::t_rsp i_rsp,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_result_count
);
    import ldw_pkg::*;

    localparam int REPORT_LINES = 40;

    logic [31:0] win_load [WIN_CAP];
    logic [15:0] last_ticket;
    logic [4:0]  win_count_reg;
    t_rsp        expected_rsps [$];
    int          fail_count   = 0;
    int          result_count = 0;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LINES) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    task automatic queue_expected(input t_rsp exp_rsp);
        expected_rsps = {expected_rsps, exp_rsp};
    endtask

    function automatic int unsigned active_windows();
        if (win_count_reg == 5'd0) begin
            return 1;
        end
        if (win_count_reg > 5'(WIN_CAP)) begin
            return WIN_CAP;
        end
        return 32'(win_count_reg);
    endfunction

    task automatic predict_request(input t_req req);
        int unsigned n;
        int unsigned best;
        logic [32:0] sum;
        t_rsp        rsp;
        n = active_windows();
        if (req.operation == OP_ENQ) begin
            if (last_ticket != TICKET_MAX) begin
                last_ticket = last_ticket + 16'd1;
            end
            best = 0;
            for (int unsigned w = 1; w < n; w++) begin
                if (win_load[w] < win_load[best]) begin
                    best = w;
                end
            end
            sum = {1'b0, win_load[best]} + {17'd0, req.duration};
            win_load[best] = sum[32] ? LOAD_MAX : sum[31:0];
            rsp.kind   = KIND_ASSIGN;
            rsp.ticket = last_ticket;
            rsp.window = 4'(best);
            rsp.load   = win_load[best];
            rsp.last   = 1'b1;
            queue_expected(rsp);
        end else begin
            for (int unsigned w = 0; w < n; w++) begin
                rsp.kind   = KIND_TOTAL;
                rsp.ticket = 16'd0;
                rsp.window = 4'(w);
                rsp.load   = win_load[w];
                rsp.last   = (w == n - 1);
                queue_expected(rsp);
            end
            for (int w = 0; w < WIN_CAP; w++) begin
                win_load[w] = 32'd0;
            end
        end
    endtask

    task automatic check_result(input t_rsp got);
        t_rsp want;
        result_count++;
        if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: kind %0d window %0d load %0d",
                                      got.kind, got.window, got.load));
            return;
        end
        want = expected_rsps.pop_front();
        if (got.kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        end
        if (got.ticket !== want.ticket) begin
            report_mismatch($sformatf("ticket %0d, expected %0d", got.ticket, want.ticket));
        end
        if (got.window !== want.window) begin
            report_mismatch($sformatf("window %0d, expected %0d", got.window, want.window));
        end
        if (got.load !== want.load) begin
            report_mismatch($sformatf("load %0d, expected %0d (window %0d)",
                                      got.load, want.load, want.window));
        end
        if (got.last !== want.last) begin
            report_mismatch($sformatf("last %0d, expected %0d (window %0d)",
                                      got.last, want.last, want.window));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WIN_CAP; w++) begin
                win_load[w] = 32'd0;
            end
            last_ticket   = 16'd0;
            win_count_reg = 5'd1;
            expected_rsps.delete();
        end else begin
            if (i_valid === 1'b1) begin
                check_result(i_rsp);
            end
            if (i_cfg_we) begin
                win_count_reg = i_cfg_wdata;
            end
            if (i_start && i_busy === 1'b0) begin
                predict_request(i_req);
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= expected_rsps.size();
        o_result_count <= result_count;
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the least loaded window dispatcher. A directed
// part covers ties, empty and full reports, the window count extremes and
// inactive windows. Random phases follow with bursty requests under several
// window counts. Checking is done in ldw_dispatch_check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ldw_pkg::*;

    localparam int ITEMS         = 380;
    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200_000;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    t_req       req       = '0;
    logic       cfg_we    = 1'b0;
    logic [4:0] cfg_wdata = 5'd0;
    logic       valid;
    t_rsp       rsp;

    int fail_count;
    int pending;
    int result_count;
    int cycles     = 0;
    int burst_left = 0;
    bit steady     = 1'b0;
    int enq_sent   = 0;
    int dist_sent  = 0;

    least_loaded_window_dispatcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_valid     (valid),
        .o_rsp       (rsp)
    );

    ldw_dispatch_check load_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_req          (req),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_valid        (valid),
        .i_rsp          (rsp),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pending);
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] pick_duration();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1:       return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic pause_sender();
        int gap;
        if (steady) begin
            return;
        end
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(12);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 25);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_request(input logic op, input logic [15:0] dur);
        start <= 1'b1;
        req   <= '{operation: op, duration: dur};
        do @(posedge i_clk); while (busy !== 1'b0);
        if (op == OP_ENQ) begin
            enq_sent++;
        end else begin
            dist_sent++;
        end
        pause_sender();
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_count(input logic [4:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [4:0] phase_count;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one window after reset
        send_request(OP_ENQ, 16'h0000);
        send_request(OP_ENQ, 16'hFFFF);
        send_request(OP_DIST, 16'h0000);
        send_request(OP_DIST, 16'hFFFF);

        // all windows, ties go to the lowest index
        write_window_count(5'd16);
        send_request(OP_ENQ, 16'd5);
        send_request(OP_ENQ, 16'd3);
        send_request(OP_ENQ, 16'hFFFF);
        send_request(OP_ENQ, 16'd0);
        send_request(OP_DIST, 16'd0);

        write_window_count(5'd0);
        send_request(OP_ENQ, 16'd7);
        send_request(OP_DIST, 16'd0);

        write_window_count(5'd31);
        send_request(OP_ENQ, 16'd1);
        send_request(OP_DIST, 16'd0);

        // shrink the count with loaded upper windows
        write_window_count(5'd4);
        send_request(OP_ENQ, 16'd10);
        send_request(OP_ENQ, 16'd20);
        send_request(OP_ENQ, 16'd30);
        send_request(OP_ENQ, 16'd40);
        write_window_count(5'd2);
        send_request(OP_ENQ, 16'd1);
        send_request(OP_DIST, 16'd0);
        write_window_count(5'd4);
        send_request(OP_DIST, 16'd0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       phase_count = 5'd1;
                1:       phase_count = 5'd16;
                2:       phase_count = 5'd0;
                3:       phase_count = 5'd31;
                6:       phase_count = 5'd16;
                7:       phase_count = 5'($urandom_range(2, 15));
                default: phase_count = 5'($urandom);
            endcase
            write_window_count(phase_count);
            steady = (p == 6);
            for (int k = 0; k < ITEMS / PHASES; k++) begin
                send_request(($urandom_range(7) == 0) ? OP_DIST : OP_ENQ, pick_duration());
            end
        end
        steady = 1'b0;

        // three windows, zero duration on a tie
        write_window_count(5'd3);
        send_request(OP_ENQ, 16'd100);
        send_request(OP_ENQ, 16'd0);
        send_request(OP_ENQ, 16'd5);
        send_request(OP_DIST, 16'd0);

        settle();
        $display("covered %0d enqueue and %0d distribute requests, %0d results checked",
                 enq_sent, dist_sent, result_count);
        $display("window counts 0, 1, 16, 31 and random, ties, shrunk counts, bursty gaps");
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
